FILE: sv/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear-probing hash table
// Operation codes, slot marks, status codes and the key hash constants.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam logic [1:0] KIND_GET  = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_FULL  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  // A 64-bit key, value or hash word.
  typedef logic [63:0] word_t;

endpackage

FILE: sv/lpht_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_hash: multi-cycle 64-bit finalizer hash
// Computes the xor-shift/multiply finalizer with 32x32 partial products,
// one partial product per cycle, and returns the full 64-bit hash.
// ----------------------------------------------------------------------------
module lpht_hash
  import lpht_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t key,
  output logic  done,
  output word_t hash
);

  // Steps: 0 lo*lo, 1 lo*hi, 2 hi*lo and combine; repeated for two rounds.
  logic        busy;
  logic        round;
  logic [1:0]  step;
  word_t       x;
  word_t       acc;
  word_t       c;
  logic [31:0] ma;
  logic [31:0] mb;
  word_t       prod;

  assign c = round ? MIX_C2 : MIX_C1;

  always_comb begin
    case (step)
      2'd0: begin
        ma = x[31:0];
        mb = c[31:0];
      end
      2'd1: begin
        ma = x[31:0];
        mb = c[63:32];
      end
      default: begin
        ma = x[63:32];
        mb = c[31:0];
      end
    endcase
  end

  assign prod = {32'd0, ma} * {32'd0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= 1'b0;
      step  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        round <= 1'b0;
        step  <= 2'd0;
        x     <= key ^ (key >> 33);
      end else if (busy) begin
        case (step)
          2'd0: begin
            acc  <= prod;
            step <= 2'd1;
          end
          2'd1: begin
            acc  <= acc + {prod[31:0], 32'd0};
            step <= 2'd2;
          end
          default: begin
            x    <= (acc + {prod[31:0], 32'd0}) ^ ((acc + {prod[31:0], 32'd0}) >> 33);
            step <= 2'd0;
            if (round) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
            round <= 1'b1;
          end
        endcase
      end
    end
  end

  assign hash = x;

endmodule

FILE: sv/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table, linear probing
// 64-bit keys and values in SLOT_COUNT slots with tombstones.
// ----------------------------------------------------------------------------
// Usage: one operation enters on the s_axis channel (tuser carries the kind,
// tdata the key and the value). Exactly one result leaves on m_axis (tuser
// carries the status, tdata the read value and the occupancy).
// The block handles one operation at a time. An operation first runs the hash
// (two rounds of three 32x32 partial products), then visits each probed slot
// in a read state and a check state, since each slot read goes through the
// registered slot memory and is then checked; a slot write happens in the
// check state itself and adds no state. The result is offered once the
// probe ends, and the next operation can be accepted in the cycle after the
// result transfer.
// After reset a clearing pass writes every slot mark to empty, one slot per
// cycle, so s_axis_tready stays low until the pass is done. When the receiver
// stalls, the result holds in the output register and no new operation is
// accepted until it has been transferred.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
)
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // key [63:0], data_in [127:64]
  input  logic [1:0]    s_axis_tuser,  // kind
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [79:0]   m_axis_tdata,  // read_value [63:0], occupancy [74:64], zero fill
  output logic [1:0]    m_axis_tuser   // status
);

  localparam int AW = $clog2(SLOT_COUNT);
  // The count holds the whole slot range; the result reports its low 11 bits.
  localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state;
  logic [AW:0]   clr_cnt;
  logic [1:0]    kind;
  word_t         key;
  word_t         din;
  logic [AW-1:0] idx;
  logic [AW:0]   visits;
  logic          tomb_seen;
  logic [AW-1:0] tomb_idx;
  logic [CW-1:0] full_count;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;

  // Slot memories with registered read data.
  logic [1:0]    mark_mem [SLOT_COUNT];
  word_t         key_mem  [SLOT_COUNT];
  word_t         val_mem  [SLOT_COUNT];
  logic [1:0]    rd_mark;
  word_t         rd_key;
  word_t         rd_val;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_mark;
  logic          wr_kv;
  word_t         wr_key;
  word_t         wr_val;

  logic  hash_done;
  word_t hash;

  lpht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (s_axis_tvalid && s_axis_tready),
    .key   (s_axis_tdata[63:0]),
    .done  (hash_done),
    .hash  (hash)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mark_mem[wr_addr] <= wr_mark;
      if (wr_kv) begin
        key_mem[wr_addr] <= wr_key;
        val_mem[wr_addr] <= wr_val;
      end
    end
    rd_mark <= mark_mem[idx];
    rd_key  <= key_mem[idx];
    rd_val  <= val_mem[idx];
  end

  logic last_visit;
  assign last_visit = (visits == (AW + 1)'(SLOT_COUNT - 1));
  assign s_axis_tready = (state == S_IDLE);
  assign count_inc = full_count + 1'b1;
  assign count_dec = full_count - 1'b1;

  // Write decisions in the clear and check states.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_mark = MARK_FULL;
    wr_kv   = 1'b0;
    wr_key  = key;
    wr_val  = din;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt[AW-1:0];
      wr_mark = MARK_EMPTY;
    end else if (state == S_CHECK) begin
      if (rd_mark == MARK_FULL && rd_key == key) begin
        if (kind == KIND_SET) begin
          wr_en = 1'b1;
          wr_kv = 1'b1;
        end else if (kind == KIND_DEL) begin
          wr_en   = 1'b1;
          wr_kv   = 1'b1;
          wr_mark = MARK_TOMB;
          wr_key  = '0;
          wr_val  = '0;
        end
      end else if (kind == KIND_SET &&
                   (rd_mark == MARK_EMPTY || (last_visit && (tomb_seen ||
                    rd_mark == MARK_TOMB)))) begin
        wr_en   = 1'b1;
        wr_kv   = 1'b1;
        wr_addr = tomb_seen ? tomb_idx : idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      full_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW + 1)'(SLOT_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind  <= s_axis_tuser;
            key   <= s_axis_tdata[63:0];
            din   <= s_axis_tdata[127:64];
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx       <= hash[AW-1:0];
            visits    <= '0;
            tomb_seen <= 1'b0;
            if (kind == KIND_NONE) begin
              m_axis_tuser  <= ST_MISS;
              m_axis_tdata  <= {5'd0, full_count[10:0], 64'd0};
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          m_axis_tdata <= {5'd0, full_count[10:0], 64'd0};
          if (rd_mark == MARK_FULL && rd_key == key) begin
            m_axis_tuser <= ST_OK;
            if (kind == KIND_GET) m_axis_tdata <= {5'd0, full_count[10:0], rd_val};
            if (kind == KIND_DEL) begin
              if (full_count != '0) begin
                full_count   <= count_dec;
                m_axis_tdata <= {5'd0, count_dec[10:0], 64'd0};
              end
            end
            m_axis_tvalid <= 1'b1;
            state         <= S_OUT;
          end else if (rd_mark == MARK_EMPTY || last_visit) begin
            m_axis_tuser <= ST_MISS;
            if (kind == KIND_SET) begin
              if (wr_en) begin
                m_axis_tuser <= ST_OK;
                full_count   <= count_inc;
                m_axis_tdata <= {5'd0, count_inc[10:0], 64'd0};
              end else begin
                m_axis_tuser <= ST_FULL;
              end
            end
            m_axis_tvalid <= 1'b1;
            state         <= S_OUT;
          end else begin
            if (rd_mark == MARK_TOMB && !tomb_seen) begin
              tomb_seen <= 1'b1;
              tomb_idx  <= idx;
            end
            idx    <= idx + 1'b1;
            visits <= visits + 1'b1;
            state  <= S_READ;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is only offered while the output state holds it.
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT)
    else $error("result valid outside output state");

  // Input is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // The occupancy never exceeds the slot count.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    full_count <= CW'(SLOT_COUNT))
    else $error("occupancy above slot count");

endmodule
